// ===== rtl/line_voxel_step_3d_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Line voxel step: assertion macros
// Shared macros for the concurrent checks on the unit's ports.
// ---------------------------------------------------------------------------
`ifndef LINE_VOXEL_STEP_3D_UNIT_DEFINES_SVH
`define LINE_VOXEL_STEP_3D_UNIT_DEFINES_SVH

// Implication check, sampled on clk_i and switched off while in reset.
`define LVS3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition never occurs out of reset.
`define LVS3_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ===== rtl/lvs3_pkg.sv =====
// ---------------------------------------------------------------------------
// Line voxel step package
// Widths, pipeline depths, types and helpers shared by the unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lvs3_pkg;

  localparam int COORD_BITS     = 16;
  localparam int DIST_FRAC_BITS = 8;
  localparam int DIST_BITS      = COORD_BITS + 1 + DIST_FRAC_BITS;
  localparam int RAD_BITS       = 2 * DIST_BITS;
  localparam int SQ_BITS        = 2 * COORD_BITS;
  localparam int SUM_BITS       = DIST_BITS + 1;
  localparam int NUM_CAND       = 7;
  localparam int NUM_DIST       = 2 * NUM_CAND;

  localparam int FRONT_LAT = 5;
  localparam int SQRT_LAT  = DIST_BITS;
  localparam int SEL_LAT   = 4;
  localparam int LATENCY   = FRONT_LAT + SQRT_LAT + SEL_LAT;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [2:0][COORD_BITS-1:0] point_t;
  typedef logic [DIST_BITS-1:0] dist_t;
  typedef logic [RAD_BITS-1:0] rad_t;
  typedef logic [SUM_BITS-1:0] sum_t;

  // Axis masks of the candidates in priority order x, y, z, xy, xz, yz, xyz.
  localparam logic [NUM_CAND-1:0][2:0] CAND_MASK =
    {3'd7, 3'd6, 3'd5, 3'd3, 3'd4, 3'd2, 3'd1};

  typedef struct packed {
    logic   reached;
    logic   [2:0] moving;
    point_t cur;
    point_t stp;
  } side_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] idx;
    sum_t       d;
  } node_t;

  function automatic coord_t abs_diff(input coord_t a, input coord_t b);
    logic signed [COORD_BITS:0] diff;
    logic signed [COORD_BITS:0] mag;
    begin
      diff = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
      mag  = diff[COORD_BITS] ? -diff : diff;
      return mag[COORD_BITS-1:0];
    end
  endfunction

  // The left node always holds the earlier candidate, so it wins ties.
  function automatic node_t pick(input node_t a, input node_t b);
    begin
      if (a.ok && (!b.ok || (a.d <= b.d))) begin
        return a;
      end
      return b;
    end
  endfunction

endpackage

// ===== rtl/line_voxel_step_3d_unit.sv =====
// ---------------------------------------------------------------------------
// Line voxel step, 3D
// One step of a voxel walk from a current point toward a line end.
//
//   channel   handshake          words
//   query     start_i / busy_o   cur_*_i, start_*_i, end_*_i
//   result    done_o (strobe)    next_*_o, reached_end_o
//
// A query is taken in every cycle; busy_o is never raised.
// Each result passes through five front-end stages, one stage per root bit
// in the square-root pipelines (25), and four stages of summing and
// selection.
// Reset clears only the valid bits; data registers are left as they are.
// Results leave in query order and cannot be held off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_voxel_step_3d_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [15:0]      cur_x_i,
  input  logic signed [15:0]      cur_y_i,
  input  logic signed [15:0]      cur_z_i,
  input  logic signed [15:0]      start_x_i,
  input  logic signed [15:0]      start_y_i,
  input  logic signed [15:0]      start_z_i,
  input  logic signed [15:0]      end_x_i,
  input  logic signed [15:0]      end_y_i,
  input  logic signed [15:0]      end_z_i,
  output logic                    done_o,
  output logic signed [15:0]      next_x_o,
  output logic signed [15:0]      next_y_o,
  output logic signed [15:0]      next_z_o,
  output logic                    reached_end_o
);
  import lvs3_pkg::*;

  point_t cur, st, en, next;
  logic   f_valid, s_valid, sel_valid;
  side_t  f_side, s_side;
  rad_t   [NUM_DIST-1:0] rad;
  dist_t  [NUM_DIST-1:0] root;
  logic   [SQRT_LAT-1:0] vdly_q;
  side_t  sdly_q [SQRT_LAT];

  assign cur = {cur_z_i, cur_y_i, cur_x_i};
  assign st  = {start_z_i, start_y_i, start_x_i};
  assign en  = {end_z_i, end_y_i, end_x_i};

  assign busy_o = 1'b0;

  lvs3_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .cur_i   (cur),
    .start_i (st),
    .end_i   (en),
    .valid_o (f_valid),
    .side_o  (f_side),
    .rad_o   (rad)
  );

  for (genvar d = 0; d < NUM_DIST; d++) begin : g_sqrt
    lvs3_isqrt u_isqrt (
      .clk_i  (clk_i),
      .rad_i  (rad[d]),
      .root_o (root[d])
    );
  end

  // Valid bits and side data ride alongside the square-root pipelines.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vdly_q <= '0;
    end else begin
      vdly_q <= {vdly_q[SQRT_LAT-2:0], f_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    sdly_q[0] <= f_side;
    for (int k = 1; k < SQRT_LAT; k++) begin
      sdly_q[k] <= sdly_q[k-1];
    end
  end

  assign s_valid = vdly_q[SQRT_LAT-1];
  assign s_side  = sdly_q[SQRT_LAT-1];

  lvs3_select u_select (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_valid),
    .side_i    (s_side),
    .dist_i    (root),
    .valid_o   (sel_valid),
    .next_o    (next),
    .reached_o (reached_end_o)
  );

  assign done_o   = sel_valid;
  assign next_x_o = next[0];
  assign next_y_o = next[1];
  assign next_z_o = next[2];

endmodule

// ===== rtl/lvs3_front.sv =====
// ---------------------------------------------------------------------------
// Line voxel step front end
// Steps each axis, forms the candidate points and builds the scaled squared
// distances over five register stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lvs3_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  lvs3_pkg::point_t                          cur_i,
  input  lvs3_pkg::point_t                          start_i,
  input  lvs3_pkg::point_t                          end_i,
  output logic                                      valid_o,
  output lvs3_pkg::side_t                           side_o,
  output lvs3_pkg::rad_t [lvs3_pkg::NUM_DIST-1:0]   rad_o
);
  import lvs3_pkg::*;

  logic   v1_q, v2_q, v3_q, v4_q, v5_q;
  point_t cur1_q, st1_q, en1_q;
  point_t cur2_q, st2_q, en2_q, stp2_q, stp2_d;
  logic   [2:0] mov2_q, mov2_d;
  side_t  side3_q, side4_q, side5_q, side3_d;
  logic   [NUM_DIST-1:0][2:0][COORD_BITS-1:0] ad3_q, ad3_d;
  logic   [NUM_DIST-1:0][2:0][SQ_BITS-1:0] sq4_q, sq4_d;
  rad_t   [NUM_DIST-1:0] rad5_q, rad5_d;
  point_t [NUM_CAND-1:0] cand;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mov2_d[i] = (cur1_q[i] != en1_q[i]);
      if ($signed(cur1_q[i]) < $signed(en1_q[i])) begin
        stp2_d[i] = cur1_q[i] + coord_t'(1);
      end else if ($signed(cur1_q[i]) > $signed(en1_q[i])) begin
        stp2_d[i] = cur1_q[i] - coord_t'(1);
      end else begin
        stp2_d[i] = cur1_q[i];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CAND; k++) begin
      for (int i = 0; i < 3; i++) begin
        cand[k][i] = CAND_MASK[k][i] ? stp2_q[i] : cur2_q[i];
      end
    end
    for (int k = 0; k < NUM_CAND; k++) begin
      for (int i = 0; i < 3; i++) begin
        ad3_d[2*k][i]   = abs_diff(st2_q[i], cand[k][i]);
        ad3_d[2*k+1][i] = abs_diff(cand[k][i], en2_q[i]);
      end
    end
    side3_d.reached = (mov2_q == 3'b000);
    side3_d.moving  = mov2_q;
    side3_d.cur     = cur2_q;
    side3_d.stp     = stp2_q;
  end

  always_comb begin
    for (int d = 0; d < NUM_DIST; d++) begin
      for (int i = 0; i < 3; i++) begin
        sq4_d[d][i] = SQ_BITS'(ad3_q[d][i]) * SQ_BITS'(ad3_q[d][i]);
      end
    end
  end

  always_comb begin
    for (int d = 0; d < NUM_DIST; d++) begin
      rad5_d[d] = (RAD_BITS'(sq4_q[d][0]) + RAD_BITS'(sq4_q[d][1])
                   + RAD_BITS'(sq4_q[d][2])) << (2 * DIST_FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur1_q  <= cur_i;
    st1_q   <= start_i;
    en1_q   <= end_i;
    cur2_q  <= cur1_q;
    st2_q   <= st1_q;
    en2_q   <= en1_q;
    stp2_q  <= stp2_d;
    mov2_q  <= mov2_d;
    ad3_q   <= ad3_d;
    side3_q <= side3_d;
    sq4_q   <= sq4_d;
    side4_q <= side3_q;
    rad5_q  <= rad5_d;
    side5_q <= side4_q;
  end

  assign valid_o = v5_q;
  assign side_o  = side5_q;
  assign rad_o   = rad5_q;

endmodule

// ===== rtl/lvs3_isqrt.sv =====
// ---------------------------------------------------------------------------
// Line voxel step square root
// Pipelined integer square root, one result bit per register stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lvs3_isqrt (
  input  logic            clk_i,
  input  lvs3_pkg::rad_t  rad_i,
  output lvs3_pkg::dist_t root_o
);
  import lvs3_pkg::*;

  rad_t                         rad_s  [DIST_BITS+1];
  logic [DIST_BITS+1:0]         rem_s  [DIST_BITS+1];
  dist_t                        root_s [DIST_BITS+1];

  assign rad_s[0]  = rad_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  for (genvar k = 0; k < DIST_BITS; k++) begin : g_stage
    logic [DIST_BITS+1:0] rem_sh, trial;
    rad_t                 rad_d;
    logic [DIST_BITS+1:0] rem_d;
    dist_t                root_d;
    logic                 fit;

    // The remainder never exceeds twice the partial root, so its top bits
    // are zero before the shift.
    assign rem_sh = {rem_s[k][DIST_BITS-1:0], rad_s[k][RAD_BITS-1:RAD_BITS-2]};
    assign trial  = {root_s[k], 2'b01};
    assign fit    = (rem_sh >= trial);
    assign rem_d  = fit ? (rem_sh - trial) : rem_sh;
    assign root_d = {root_s[k][DIST_BITS-2:0], fit};
    assign rad_d  = rad_s[k] << 2;

    always_ff @(posedge clk_i) begin
      rad_s[k+1]  <= rad_d;
      rem_s[k+1]  <= rem_d;
      root_s[k+1] <= root_d;
    end
  end

  assign root_o = root_s[DIST_BITS];

endmodule

// ===== rtl/lvs3_select.sv =====
// ---------------------------------------------------------------------------
// Line voxel step selector
// Adds the two distances of each candidate and picks the least through a
// registered three-level tree; the last level holds the result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lvs3_select (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  input  lvs3_pkg::side_t                          side_i,
  input  lvs3_pkg::dist_t [lvs3_pkg::NUM_DIST-1:0] dist_i,
  output logic                                     valid_o,
  output lvs3_pkg::point_t                         next_o,
  output logic                                     reached_o
);
  import lvs3_pkg::*;

  logic   v1_q, v2_q, v3_q, v4_q;
  side_t  side1_q, side2_q, side3_q;
  node_t  [NUM_CAND-1:0] n1_q, n1_d;
  node_t  [3:0] n2_q, n2_d;
  node_t  [1:0] n3_q, n3_d;
  node_t  win;
  point_t next_q, next_d;
  logic   reached_q;

  always_comb begin
    for (int k = 0; k < NUM_CAND; k++) begin
      n1_d[k].ok  = |(CAND_MASK[k] & side_i.moving);
      n1_d[k].idx = 3'(k);
      n1_d[k].d   = SUM_BITS'(dist_i[2*k]) + SUM_BITS'(dist_i[2*k+1]);
    end
    n2_d[0] = pick(n1_q[0], n1_q[1]);
    n2_d[1] = pick(n1_q[2], n1_q[3]);
    n2_d[2] = pick(n1_q[4], n1_q[5]);
    n2_d[3] = n1_q[6];
    n3_d[0] = pick(n2_q[0], n2_q[1]);
    n3_d[1] = pick(n2_q[2], n2_q[3]);
    win     = pick(n3_q[0], n3_q[1]);
    for (int i = 0; i < 3; i++) begin
      if (!side3_q.reached && CAND_MASK[win.idx][i]) begin
        next_d[i] = side3_q.stp[i];
      end else begin
        next_d[i] = side3_q.cur[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q      <= n1_d;
    side1_q   <= side_i;
    n2_q      <= n2_d;
    side2_q   <= side1_q;
    n3_q      <= n3_d;
    side3_q   <= side2_q;
    next_q    <= next_d;
    reached_q <= side3_q.reached;
  end

  assign valid_o   = v4_q;
  assign next_o    = next_q;
  assign reached_o = reached_q;

endmodule

// ===== rtl/lvs3_checker.sv =====
// ---------------------------------------------------------------------------
// Line voxel step port checker
// Checks latency and result properties seen on the unit's ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_voxel_step_3d_unit_defines.svh"

module lvs3_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic signed [15:0] cur_x_i,
  input logic signed [15:0] cur_y_i,
  input logic signed [15:0] cur_z_i,
  input logic signed [15:0] end_x_i,
  input logic signed [15:0] end_y_i,
  input logic signed [15:0] end_z_i,
  input logic               done_o,
  input logic signed [15:0] next_x_o,
  input logic signed [15:0] next_y_o,
  input logic signed [15:0] next_z_o,
  input logic               reached_end_o
);
  import lvs3_pkg::*;

  `LVS3_ASSERT_NEVER(a_never_busy, busy_o, "unit raised busy")

  `LVS3_ASSERT_IMP(a_latency, done_o, $past(start_i, LATENCY), "result without a query")

  // A query that sits on its end point must return the end point itself.
  `LVS3_ASSERT_IMP(a_reached, done_o && reached_end_o, (next_x_o == $past(end_x_i, LATENCY)) && (next_y_o == $past(end_y_i, LATENCY)) && (next_z_o == $past(end_z_i, LATENCY)), "end point not returned")

  // Otherwise the walk must move on at least one axis.
  `LVS3_ASSERT_IMP(a_moved, done_o && !reached_end_o, (next_x_o != $past(cur_x_i, LATENCY)) || (next_y_o != $past(cur_y_i, LATENCY)) || (next_z_o != $past(cur_z_i, LATENCY)), "step did not move")

endmodule

bind line_voxel_step_3d_unit lvs3_checker u_lvs3_checker (.*);
